// ===== sv/fstm_pkg.sv =====
// ----------------------------------------------------------------------------
// fstm_pkg: shared types and constants of the flat span texture mapper
// Word layouts of both streams, action codes and the walker control group.
// ----------------------------------------------------------------------------
package fstm_pkg;

  // Texture is a fixed 64 x 64 byte square
  localparam int TexSideLog2 = 6;
  localparam int TexAw       = 2 * TexSideLog2;
  localparam int TexDepth    = 1 << TexAw;
  localparam int ColW        = 11;
  localparam int RowW        = 10;
  localparam int PosW        = 32;
  localparam int FracW       = 16;
  localparam int InDataW     = 192;
  localparam int OutDataW    = 40;

  typedef enum logic [1:0] {
    ACT_LOAD_TEX  = 2'd0,
    ACT_LOAD_CMAP = 2'd1,
    ACT_START     = 2'd2,
    ACT_CONTINUE  = 2'd3
  } fstm_action_t;

  // Input word, last declared field (load_address) in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [4:0]         map_select;
    logic [RowW-1:0]    row;
    logic [9:0]         x_start;
    logic [5:0]         step_count;
    logic signed [31:0] v_step;
    logic signed [31:0] u_step;
    logic signed [31:0] v_start;
    logic signed [31:0] u_start;
    logic [15:0]        load_data;
    logic [12:0]        load_address;
  } fstm_in_word_t;

  typedef struct packed {
    logic [2:0]      pad;
    logic [15:0]     color;
    logic [RowW-1:0] pixel_y;
    logic [ColW-1:0] pixel_x;
  } fstm_out_word_t;

  // Sequencer to walker
  typedef struct packed {
    logic latch;    // take the start fields
    logic add_u;    // shared adder: u += du
    logic add_v;    // shared adder: v += dv
    logic col_one;  // column += 1
    logic col_two;  // column += 2
  } fstm_walk_ctrl_t;

endpackage

// ===== sv/fstm_tex_store.sv =====
// ----------------------------------------------------------------------------
// fstm_tex_store: texture memory
// 64 x 64 bytes, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fstm_tex_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [fstm_pkg::TexAw-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [fstm_pkg::TexAw-1:0] rd_addr,
  output logic [7:0]                rd_data_r
);

  logic [7:0] mem [fstm_pkg::TexDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fstm_cmap_store.sv =====
// ----------------------------------------------------------------------------
// fstm_cmap_store: light colormap memory
// LIGHT_LEVELS maps of 256 hicolour entries, registered read.
// ----------------------------------------------------------------------------
module fstm_cmap_store #(
  parameter int LIGHT_LEVELS = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(LIGHT_LEVELS*256)-1:0]    wr_addr,
  input  logic [15:0]                            wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(LIGHT_LEVELS*256)-1:0]    rd_addr,
  output logic [15:0]                            rd_data_r
);

  localparam int Depth = LIGHT_LEVELS * 256;

  logic [15:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fstm_walker.sv =====
// ----------------------------------------------------------------------------
// fstm_walker: span position state and shared step adder
// Holds u, v, their steps, column, row and map; one 32-bit adder advances
// u and v in separate cycles.
// ----------------------------------------------------------------------------
module fstm_walker #(
  parameter int LIGHT_LEVELS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fstm_pkg::fstm_walk_ctrl_t              ctrl,
  input  logic                                   low_detail,
  input  logic signed [31:0]                     u_start,
  input  logic signed [31:0]                     v_start,
  input  logic signed [31:0]                     u_step,
  input  logic signed [31:0]                     v_step,
  input  logic [9:0]                             x_start,
  input  logic [fstm_pkg::RowW-1:0]              row,
  input  logic [4:0]                             map_select,
  output logic [fstm_pkg::TexAw-1:0]             tex_addr,
  output logic [((LIGHT_LEVELS > 1) ? $clog2(LIGHT_LEVELS) : 1)-1:0] map,
  output logic [fstm_pkg::ColW-1:0]              column,
  output logic [fstm_pkg::RowW-1:0]              span_row
);

  localparam int MapW = (LIGHT_LEVELS > 1) ? $clog2(LIGHT_LEVELS) : 1;
  localparam int Hi   = fstm_pkg::FracW + fstm_pkg::TexSideLog2 - 1;

  logic [fstm_pkg::PosW-1:0] u_r, u_nxt, v_r, v_nxt, du_r, du_nxt, dv_r, dv_nxt;
  logic [fstm_pkg::ColW-1:0] col_r, col_nxt;
  logic [fstm_pkg::RowW-1:0] row_r, row_nxt;
  logic [MapW-1:0]           map_r, map_nxt;
  logic [fstm_pkg::PosW-1:0] add_a, add_b, add_sum;

  // Shared adder: v when asked, u otherwise
  assign add_a   = ctrl.add_v ? v_r  : u_r;
  assign add_b   = ctrl.add_v ? dv_r : du_r;
  assign add_sum = add_a + add_b;

  always_comb begin
    u_nxt   = u_r;
    v_nxt   = v_r;
    du_nxt  = du_r;
    dv_nxt  = dv_r;
    col_nxt = col_r;
    row_nxt = row_r;
    map_nxt = map_r;
    if (ctrl.latch) begin
      u_nxt   = u_start;
      v_nxt   = v_start;
      du_nxt  = u_step;
      dv_nxt  = v_step;
      col_nxt = low_detail ? {x_start, 1'b0} : {1'b0, x_start};
      row_nxt = row;
      if (32'(map_select) > LIGHT_LEVELS - 1) begin
        map_nxt = MapW'(LIGHT_LEVELS - 1);
      end else begin
        map_nxt = MapW'(map_select);
      end
    end
    if (ctrl.add_u) begin
      u_nxt = add_sum;
    end
    if (ctrl.add_v) begin
      v_nxt = add_sum;
    end
    if (ctrl.col_one) begin
      col_nxt = col_r + fstm_pkg::ColW'(1);
    end
    if (ctrl.col_two) begin
      col_nxt = col_r + fstm_pkg::ColW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r   <= '0;
      v_r   <= '0;
      du_r  <= '0;
      dv_r  <= '0;
      col_r <= '0;
      row_r <= '0;
      map_r <= '0;
    end else begin
      u_r   <= u_nxt;
      v_r   <= v_nxt;
      du_r  <= du_nxt;
      dv_r  <= dv_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      map_r <= map_nxt;
    end
  end

  assign tex_addr = {v_r[Hi:fstm_pkg::FracW], u_r[Hi:fstm_pkg::FracW]};
  assign map      = map_r;
  assign column   = col_r;
  assign span_row = row_r;

endmodule

// ===== sv/flat_span_texture_mapper_top.sv =====
// A load word is written on the accept edge. A span word runs each texture step
// through the texture read, colormap read and output load in turn, with a second
// output load at the next column in low detail. The input is not ready until the
// last output of the span is loaded; output backpressure stalls the output loads.
// Reset: control returns to idle, mode and span state clear to zero; texture and
// colormap memories are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// flat_span_texture_mapper_top: affine floor/ceiling span renderer
// Sequencer around the walker, texture memory and colormap memory.
// ----------------------------------------------------------------------------
module flat_span_texture_mapper_top #(
  parameter int LIGHT_LEVELS = 32,
  parameter int MAX_STEPS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,   // low_detail
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // load_address, load_data, u_start, v_start, u_step, v_step, step_count,
  // x_start, row, map_select
  input  logic [fstm_pkg::InDataW-1:0]     in_tdata,
  input  logic [1:0]                       in_tuser,      // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fstm_pkg::OutDataW-1:0]    out_tdata,     // pixel_x, pixel_y, color
  output logic                             out_tlast      // last
);

  localparam int MapW    = (LIGHT_LEVELS > 1) ? $clog2(LIGHT_LEVELS) : 1;
  localparam int CmapAw  = $clog2(LIGHT_LEVELS * 256);
  localparam int CntW    = $clog2(MAX_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TEX   = 5'b00010,
    S_CMAP  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_EMIT2 = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CntW-1:0]           remain_r, remain_nxt, steps_sat;
  logic                      low_detail_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r, out_last_nxt;
  fstm_pkg::fstm_out_word_t  out_word_r, out_word_nxt;
  fstm_pkg::fstm_in_word_t   in_word;
  fstm_pkg::fstm_action_t    action;
  fstm_pkg::fstm_walk_ctrl_t walk_ctrl;
  logic                      accept, out_free, final_step;
  logic                      tex_we, tex_re, cmap_we, cmap_re;
  logic [7:0]                texel_r;
  logic [15:0]               color_r;
  logic [fstm_pkg::TexAw-1:0] tex_addr;
  logic [MapW-1:0]           map;
  logic [fstm_pkg::ColW-1:0] column;
  logic [fstm_pkg::RowW-1:0] span_row;

  assign in_word    = fstm_pkg::fstm_in_word_t'(in_tdata);
  assign action     = fstm_pkg::fstm_action_t'(in_tuser);
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign final_step = (remain_r == CntW'(1));

  always_comb begin
    if (32'(in_word.step_count) > MAX_STEPS) begin
      steps_sat = CntW'(MAX_STEPS);
    end else begin
      steps_sat = CntW'(in_word.step_count);
    end
  end

  // Loads land on the accept edge; out-of-range addresses are dropped
  assign tex_we  = accept && (action == fstm_pkg::ACT_LOAD_TEX)
                   && (32'(in_word.load_address) < fstm_pkg::TexDepth);
  assign cmap_we = accept && (action == fstm_pkg::ACT_LOAD_CMAP)
                   && (32'(in_word.load_address) < LIGHT_LEVELS * 256);
  assign tex_re  = (state_r == S_TEX);
  assign cmap_re = (state_r == S_CMAP);

  always_comb begin
    state_nxt     = state_r;
    remain_nxt    = remain_r;
    walk_ctrl     = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (action == fstm_pkg::ACT_START || action == fstm_pkg::ACT_CONTINUE)) begin
          walk_ctrl.latch = (action == fstm_pkg::ACT_START);
          remain_nxt      = steps_sat;
          if (steps_sat != '0) begin
            state_nxt = S_TEX;
          end
        end
      end
      S_TEX: begin
        walk_ctrl.add_u = 1'b1;
        state_nxt       = S_CMAP;
      end
      S_CMAP: begin
        walk_ctrl.add_v = 1'b1;
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.pad     = '0;
          out_word_nxt.pixel_x = column;
          out_word_nxt.pixel_y = span_row;
          out_word_nxt.color   = color_r;
          out_last_nxt         = final_step && !low_detail_r;
          if (low_detail_r) begin
            state_nxt = S_EMIT2;
          end else begin
            walk_ctrl.col_one = 1'b1;
            remain_nxt        = remain_r - CntW'(1);
            state_nxt         = final_step ? S_IDLE : S_TEX;
          end
        end
      end
      S_EMIT2: begin
        // duplicate texel at the next column
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.pixel_x = column + fstm_pkg::ColW'(1);
          out_last_nxt         = final_step;
          walk_ctrl.col_two    = 1'b1;
          remain_nxt           = remain_r - CntW'(1);
          state_nxt            = final_step ? S_IDLE : S_TEX;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      remain_r     <= '0;
      low_detail_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        low_detail_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  fstm_walker #(
    .LIGHT_LEVELS (LIGHT_LEVELS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (walk_ctrl),
    .low_detail (low_detail_r),
    .u_start    (in_word.u_start),
    .v_start    (in_word.v_start),
    .u_step     (in_word.u_step),
    .v_step     (in_word.v_step),
    .x_start    (in_word.x_start),
    .row        (in_word.row),
    .map_select (in_word.map_select),
    .tex_addr   (tex_addr),
    .map        (map),
    .column     (column),
    .span_row   (span_row)
  );

  fstm_tex_store u_tex_store (
    .clk       (clk),
    .wr_en     (tex_we),
    .wr_addr   (fstm_pkg::TexAw'(in_word.load_address)),
    .wr_data   (in_word.load_data[7:0]),
    .rd_en     (tex_re),
    .rd_addr   (tex_addr),
    .rd_data_r (texel_r)
  );

  fstm_cmap_store #(
    .LIGHT_LEVELS (LIGHT_LEVELS)
  ) u_cmap_store (
    .clk       (clk),
    .wr_en     (cmap_we),
    .wr_addr   (CmapAw'(in_word.load_address)),
    .wr_data   (in_word.load_data),
    .rd_en     (cmap_re),
    .rd_addr   (CmapAw'({map, texel_r})),
    .rd_data_r (color_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

endmodule
